@@ hw/rtl/fce_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fce_pkg
// Shared types, constants and helper functions of the convolutional encoder.
// ----------------------------------------------------------------------------
package fce_pkg;

	localparam int POLY_REGS   = 4;
	localparam int POLY_W      = 9;
	localparam int MEM_W       = 8;
	localparam int MLEN_W      = 4;
	localparam int NPOL_W      = 3;
	localparam int FLEN_W      = 16;
	localparam int MAX_MEMORY  = 8;
	localparam int MAX_POLYS   = 4;
	localparam int CODED_W     = 4;
	localparam int IN_DATA_W   = 8;
	localparam int OUT_DATA_W  = 8;
	localparam int OUT_USER_W  = 3;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = $clog2(QDEPTH + 1);

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POLY_ZERO    = 3'd0,
		REG_POLY_ONE     = 3'd1,
		REG_POLY_TWO     = 3'd2,
		REG_POLY_THREE   = 3'd3,
		REG_NUM_POLYS    = 3'd4,
		REG_FRAME_LENGTH = 3'd5
	} cfg_reg_t;

	// Class of an accepted item as decided by the front end.
	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_END  = 2'd1,
		KIND_ERR  = 2'd2
	} item_kind_t;

	typedef struct packed {
		item_kind_t kind;
		logic       info_bit;
	} q_entry_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	typedef struct packed {
		logic [POLY_REGS-1:0][POLY_W-1:0] poly;
		logic [NPOL_W-1:0]                num_polys;
		logic [FLEN_W-1:0]                frame_length;
	} cfg_t;

	typedef struct packed {
		logic [CODED_W-1:0] coded;
		logic [MEM_W-1:0]   mem_next;
	} enc_res_t;

	// Number of active generators, clamped to the supported range.
	function automatic logic [NPOL_W-1:0] active_polys(input logic [NPOL_W-1:0] num);
		logic [NPOL_W-1:0] n;
		n = num;
		if (n < NPOL_W'(2)) n = NPOL_W'(2);
		if (n > NPOL_W'(MAX_POLYS)) n = NPOL_W'(MAX_POLYS);
		if (n > NPOL_W'(POLY_REGS)) n = NPOL_W'(POLY_REGS);
		return n;
	endfunction

	// Memory length: index of the highest set bit of the largest active polynomial.
	function automatic logic [MLEN_W-1:0] mem_len(input cfg_t cfg);
		logic [NPOL_W-1:0] n;
		logic [POLY_W-1:0] top;
		logic [MLEN_W-1:0] m;
		n   = active_polys(cfg.num_polys);
		top = '0;
		m   = '0;
		for (int p = 0; p < POLY_REGS; p++) begin
			if (NPOL_W'(p) < n && cfg.poly[p] > top) top = cfg.poly[p];
		end
		for (int i = 1; i < POLY_W; i++) begin
			if (top[i]) m = MLEN_W'(i);
		end
		if (m > MLEN_W'(MAX_MEMORY)) m = MLEN_W'(MAX_MEMORY);
		return m;
	endfunction

	// One encoder step: parities of the working register and the next memory.
	function automatic enc_res_t encode(input logic bit_in, input logic [MEM_W-1:0] mem,
	                                    input logic [MLEN_W-1:0] m, input cfg_t cfg);
		logic [NPOL_W-1:0] n;
		logic [POLY_W-1:0] wreg;
		logic [POLY_W-1:0] mem_ext;
		enc_res_t          res;
		n       = active_polys(cfg.num_polys);
		mem_ext = {1'b0, mem};
		for (int i = 0; i < POLY_W; i++) begin
			if (MLEN_W'(i) == m) wreg[i] = bit_in;
			else if (MLEN_W'(i) < m) wreg[i] = mem_ext[i];
			else wreg[i] = 1'b0;
		end
		for (int p = 0; p < CODED_W; p++) begin
			if (p < POLY_REGS && NPOL_W'(p) < n) res.coded[p] = ^(wreg & cfg.poly[p]);
			else res.coded[p] = 1'b0;
		end
		res.mem_next = wreg[POLY_W-1:1];
		return res;
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/fce_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fce_queue
// Small FIFO of classified items between the front end and the back end.
// ----------------------------------------------------------------------------
module fce_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire fce_pkg::q_entry_t  push_entry,
	input  wire logic               pop,
	output fce_pkg::q_entry_t       head,
	output fce_pkg::q_status_t      status
);

	fce_pkg::q_entry_t                  slots_q [fce_pkg::QDEPTH];
	logic [fce_pkg::QPTR_W-1:0]         wr_ptr_q;
	logic [fce_pkg::QPTR_W-1:0]         rd_ptr_q;
	logic [fce_pkg::QCNT_W-1:0]         cnt_q;

	always_ff @(posedge clk) begin
		if (push) slots_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + fce_pkg::QPTR_W'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + fce_pkg::QPTR_W'(1);
			if (push && !pop) cnt_q <= cnt_q + fce_pkg::QCNT_W'(1);
			else if (pop && !push) cnt_q <= cnt_q - fce_pkg::QCNT_W'(1);
		end
	end

	assign head         = slots_q[rd_ptr_q];
	assign status.empty = (cnt_q == '0);
	assign status.full  = (cnt_q == fce_pkg::QCNT_W'(fce_pkg::QDEPTH));

endmodule
`default_nettype wire

@@ hw/rtl/fce_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fce_front
// Accepts information bits, counts them and marks frame ends and errors.
// ----------------------------------------------------------------------------
module fce_front #(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              info_bit,
	input  wire fce_pkg::cfg_t     cfg,
	input  wire fce_pkg::q_status_t q_status,
	output logic                   push,
	output fce_pkg::q_entry_t      push_entry
);

	localparam int CMP_W = (COUNT_WIDTH + 1 > fce_pkg::FLEN_W) ?
	                       (COUNT_WIDTH + 1) : fce_pkg::FLEN_W;

	logic [COUNT_WIDTH-1:0]      count_q;
	logic [COUNT_WIDTH:0]        next_cnt;
	logic [fce_pkg::FLEN_W-1:0]  fl_eff;
	logic                        frame_done;
	logic                        no_memory;

	assign in_ready  = !q_status.full;
	assign push      = in_valid && !q_status.full;
	assign no_memory = (fce_pkg::mem_len(cfg) == '0);

	assign next_cnt   = {1'b0, count_q} + (COUNT_WIDTH + 1)'(1);
	assign fl_eff     = (cfg.frame_length == '0) ? fce_pkg::FLEN_W'(1) : cfg.frame_length;
	// The frame also closes when the counter would wrap.
	assign frame_done = next_cnt[COUNT_WIDTH] || (CMP_W'(next_cnt) >= CMP_W'(fl_eff));

	always_comb begin
		push_entry.info_bit = info_bit;
		if (no_memory) push_entry.kind = fce_pkg::KIND_ERR;
		else if (frame_done) push_entry.kind = fce_pkg::KIND_END;
		else push_entry.kind = fce_pkg::KIND_DATA;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (push && !no_memory) begin
			count_q <= frame_done ? '0 : next_cnt[COUNT_WIDTH-1:0];
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/fce_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fce_back
// Encodes queued items, appends the zero tail and holds the output register.
// ----------------------------------------------------------------------------
module fce_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire fce_pkg::cfg_t                 cfg,
	input  wire fce_pkg::q_entry_t             head,
	input  wire fce_pkg::q_status_t            q_status,
	output logic                               pop,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [fce_pkg::CODED_W-1:0]        coded_bits,
	output logic                               is_tail,
	output logic                               last_of_run,
	output logic                               frame_end,
	output logic                               config_error
);

	logic [fce_pkg::MEM_W-1:0]   mem_q;
	logic [fce_pkg::MLEN_W-1:0]  tail_cnt_q;
	logic                        out_valid_q;
	logic [fce_pkg::CODED_W-1:0] coded_q;
	logic                        tail_q;
	logic                        last_q;
	logic                        fend_q;
	logic                        err_q;

	logic                        advance;
	logic                        in_tail;
	logic [fce_pkg::MLEN_W-1:0]  m;
	fce_pkg::enc_res_t           enc;

	assign m       = fce_pkg::mem_len(cfg);
	assign advance = !out_valid_q || out_ready;
	assign in_tail = (tail_cnt_q != '0);
	assign pop     = advance && !in_tail && !q_status.empty;
	assign enc     = fce_pkg::encode(in_tail ? 1'b0 : head.info_bit, mem_q, m, cfg);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_q       <= '0;
			tail_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			if (in_tail) begin
				mem_q       <= (tail_cnt_q == fce_pkg::MLEN_W'(1)) ? '0 : enc.mem_next;
				tail_cnt_q  <= tail_cnt_q - fce_pkg::MLEN_W'(1);
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b1;
				case (head.kind)
					fce_pkg::KIND_DATA: begin
						mem_q <= enc.mem_next;
					end
					fce_pkg::KIND_END: begin
						mem_q      <= enc.mem_next;
						tail_cnt_q <= m;
					end
					default: begin
					end
				endcase
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (in_tail) begin
				coded_q <= enc.coded;
				tail_q  <= 1'b1;
				last_q  <= (tail_cnt_q == fce_pkg::MLEN_W'(1));
				fend_q  <= (tail_cnt_q == fce_pkg::MLEN_W'(1));
				err_q   <= 1'b0;
			end else begin
				case (head.kind)
					fce_pkg::KIND_DATA: begin
						coded_q <= enc.coded;
						tail_q  <= 1'b0;
						last_q  <= 1'b1;
						fend_q  <= 1'b0;
						err_q   <= 1'b0;
					end
					fce_pkg::KIND_END: begin
						coded_q <= enc.coded;
						tail_q  <= 1'b0;
						last_q  <= 1'b0;
						fend_q  <= 1'b0;
						err_q   <= 1'b0;
					end
					default: begin
						coded_q <= '0;
						tail_q  <= 1'b0;
						last_q  <= 1'b1;
						fend_q  <= 1'b0;
						err_q   <= 1'b1;
					end
				endcase
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign coded_bits   = coded_q;
	assign is_tail      = tail_q;
	assign last_of_run  = last_q;
	assign frame_end    = fend_q;
	assign config_error = err_q;

endmodule
`default_nettype wire

@@ hw/rtl/feedforward_convolutional_encoder_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// feedforward_convolutional_encoder_core
// Zero-terminated feedforward rate 1/n convolutional encoder.
// ----------------------------------------------------------------------------
// Usage: information bits arrive as beats on the s_axis channel, one bit in
// tdata bit 0. Each beat yields one coded beat on the m_axis channel, and the
// beat that completes a frame is followed by m zero-tail beats, where m is the
// memory length derived from the largest active generator polynomial.
// Generators, rate and frame length are set through the cfg_* write port; the
// user must write them only while the block is idle; the block does not enforce it.
// An accepted beat is written into the queue, then popped by the back end and
// held in its output register, from which it shows on m_axis. Throughput is
// one information bit per cycle while the receiver takes beats; the zero tail
// of a frame stops pops from the queue. A two-entry queue separates the
// classifying front end from the encoding back end, so a stalled receiver or a
// tail only stops input once the queue is full; no beat is lost or repeated.
// Reset clears the bit counter, the encoder memory, the queue and the output
// valid flag, and returns all configuration registers to their defaults.
// ----------------------------------------------------------------------------
module feedforward_convolutional_encoder_core #(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// Bit 0: info_bit, upper bits zero.
	input  wire logic [fce_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// Bits 3:0: coded_bits, upper bits zero.
	output logic [fce_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
	// Bit 0: is_tail, bit 1: last_of_run, bit 2: config_error.
	output logic [fce_pkg::OUT_USER_W-1:0]         m_axis_tuser,
	// Marks the final beat of a frame (frame_end).
	output logic                                   m_axis_tlast,
	input  wire logic                              cfg_wr_en,
	input  wire logic [fce_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [fce_pkg::CFG_DATA_W-1:0]    cfg_data
);

	fce_pkg::cfg_t                 cfg_q;
	fce_pkg::q_status_t            q_status;
	fce_pkg::q_entry_t             push_entry;
	fce_pkg::q_entry_t             head;
	logic                          push;
	logic                          pop;
	logic [fce_pkg::CODED_W-1:0]   coded_bits;
	logic                          is_tail;
	logic                          last_of_run;
	logic                          frame_end;
	logic                          config_error;

	// Configuration registers; writes to unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.poly[0]      <= fce_pkg::POLY_W'(7);
			cfg_q.poly[1]      <= fce_pkg::POLY_W'(5);
			cfg_q.poly[2]      <= '0;
			cfg_q.poly[3]      <= '0;
			cfg_q.num_polys    <= fce_pkg::NPOL_W'(2);
			cfg_q.frame_length <= fce_pkg::FLEN_W'(64);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				fce_pkg::REG_POLY_ZERO:    cfg_q.poly[0] <= cfg_data[fce_pkg::POLY_W-1:0];
				fce_pkg::REG_POLY_ONE:     cfg_q.poly[1] <= cfg_data[fce_pkg::POLY_W-1:0];
				fce_pkg::REG_POLY_TWO:     cfg_q.poly[2] <= cfg_data[fce_pkg::POLY_W-1:0];
				fce_pkg::REG_POLY_THREE:   cfg_q.poly[3] <= cfg_data[fce_pkg::POLY_W-1:0];
				fce_pkg::REG_NUM_POLYS:    cfg_q.num_polys <= cfg_data[fce_pkg::NPOL_W-1:0];
				fce_pkg::REG_FRAME_LENGTH: cfg_q.frame_length <= cfg_data[fce_pkg::FLEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	fce_front #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.info_bit   (s_axis_tdata[0]),
		.cfg        (cfg_q),
		.q_status   (q_status),
		.push       (push),
		.push_entry (push_entry)
	);

	fce_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (q_status)
	);

	fce_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head         (head),
		.q_status     (q_status),
		.pop          (pop),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.coded_bits   (coded_bits),
		.is_tail      (is_tail),
		.last_of_run  (last_of_run),
		.frame_end    (frame_end),
		.config_error (config_error)
	);

	assign m_axis_tdata = {{(fce_pkg::OUT_DATA_W - fce_pkg::CODED_W){1'b0}}, coded_bits};
	assign m_axis_tuser = {config_error, last_of_run, is_tail};
	assign m_axis_tlast = frame_end;

endmodule
`default_nettype wire

@@ hw/rtl/fce_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fce_checker
// Port-level checks of the convolutional encoder, bound to the top level.
// ----------------------------------------------------------------------------
module fce_checker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	input  wire logic [fce_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	input  wire logic [fce_pkg::OUT_USER_W-1:0]  m_axis_tuser,
	input  wire logic                            m_axis_tlast
);

	// A stalled output beat keeps its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("output beat changed while stalled");

	// The end of a frame is always the last tail beat of its run.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0] && m_axis_tuser[1] && !m_axis_tuser[2])
		else $error("frame end outside a closing tail beat");

	// An error beat carries no code bits and closes its run alone.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[2] |->
		m_axis_tdata == '0 && !m_axis_tuser[0] && m_axis_tuser[1] && !m_axis_tlast)
		else $error("malformed configuration error beat");

	// Tail beats follow one another without a gap once taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tuser[0] && !m_axis_tuser[1] |=>
		m_axis_tvalid && m_axis_tuser[0])
		else $error("tail sequence interrupted");

endmodule

bind feedforward_convolutional_encoder_core fce_checker u_fce_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

@@ tb/fce_coded_stream_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fce_coded_stream_checker
// Watches the configuration port and both streams of the convolutional
// encoder. It keeps its own copy of the generators, the encoder memory and the
// frame bit count, works out the coded beats that each information bit must
// produce, and compares every coded beat against the oldest one still owed.
// ----------------------------------------------------------------------------
module fce_coded_stream_checker
	import fce_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	input  wire logic                  s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	input  wire logic                  m_tvalid,
	input  wire logic                  m_tready,
	input  wire logic [OUT_DATA_W-1:0] m_tdata,
	input  wire logic [OUT_USER_W-1:0] m_tuser,
	input  wire logic                  m_tlast,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output int unsigned                mismatches,
	output int unsigned                outstanding
);

	localparam int unsigned REPORT_LIMIT = 10;
	localparam int unsigned COUNT_MAX    = (1 << FLEN_W) - 1;

	typedef struct packed {
		logic [CODED_W-1:0] coded;
		logic               is_tail;
		logic               last_of_run;
		logic               frame_end;
		logic               config_error;
	} code_beat_t;

	logic [POLY_W-1:0] gen_poly [POLY_REGS];
	logic [NPOL_W-1:0] rate_denom;
	logic [FLEN_W-1:0] frame_len;
	logic [MEM_W-1:0]  enc_memory;
	int unsigned       bits_in_frame;
	code_beat_t        owed_code_beats[$];

	function automatic void owe_beat(input logic [CODED_W-1:0] coded, input logic tail,
	                                 input logic last, input logic fend, input logic err);
		owed_code_beats.push_back('{coded, tail, last, fend, err});
	endfunction

	// Shifts one bit into the encoder memory and returns its parities.
	function automatic logic [CODED_W-1:0] shift_in(input logic b, input int unsigned m,
	                                                input int unsigned n);
		logic [POLY_W-1:0]  wreg;
		logic [POLY_W-1:0]  wmask;
		logic [CODED_W-1:0] code;
		wmask = POLY_W'((1 << (m + 1)) - 1);
		wreg  = POLY_W'((int'(b) << m) | (int'(enc_memory) & ((1 << m) - 1)));
		code  = '0;
		for (int p = 0; p < n; p++) code[p] = ^(wreg & gen_poly[p] & wmask);
		enc_memory = MEM_W'(wreg >> 1);
		return code;
	endfunction

	task automatic encode_info_bit(input logic b);
		int unsigned n;
		int unsigned top;
		int unsigned m;
		int unsigned fl;
		int unsigned next;
		logic [CODED_W-1:0] code;
		n = rate_denom;
		if (n < 2) n = 2;
		if (n > MAX_POLYS) n = MAX_POLYS;
		if (n > POLY_REGS) n = POLY_REGS;
		top = 0;
		for (int p = 0; p < n; p++) if (gen_poly[p] > top) top = gen_poly[p];
		m = 0;
		while (top > 1) begin
			top = top >> 1;
			m++;
		end
		if (m > MAX_MEMORY) m = MAX_MEMORY;
		// No memory at all: a lone error beat, state untouched.
		if (m == 0) begin
			owe_beat('0, 1'b0, 1'b1, 1'b0, 1'b1);
			return;
		end
		code = shift_in(b, m, n);
		fl   = (frame_len == 0) ? 1 : frame_len;
		next = bits_in_frame + 1;
		if (next < fl && next <= COUNT_MAX) begin
			bits_in_frame = next;
			owe_beat(code, 1'b0, 1'b1, 1'b0, 1'b0);
			return;
		end
		// Frame closes: the data beat, then m zero tail beats.
		owe_beat(code, 1'b0, 1'b0, 1'b0, 1'b0);
		for (int i = 0; i < m; i++) begin
			code = shift_in(1'b0, m, n);
			owe_beat(code, 1'b1, i + 1 == m, i + 1 == m, 1'b0);
		end
		enc_memory    = '0;
		bits_in_frame = 0;
	endtask

	task automatic check_code_beat();
		code_beat_t want;
		if (owed_code_beats.size() == 0) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("%0t: unexpected coded beat tdata=%h tuser=%b tlast=%b",
				         $realtime, m_tdata, m_tuser, m_tlast);
			return;
		end
		want = owed_code_beats.pop_front();
		if (m_tdata != OUT_DATA_W'(want.coded) || m_tlast != want.frame_end ||
		    m_tuser != {want.config_error, want.last_of_run, want.is_tail}) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("%0t: expected tdata=%h tuser=%b tlast=%b, got %h %b %b",
				         $realtime, OUT_DATA_W'(want.coded),
				         {want.config_error, want.last_of_run, want.is_tail},
				         want.frame_end, m_tdata, m_tuser, m_tlast);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_poly[0]   = POLY_W'(7);
			gen_poly[1]   = POLY_W'(5);
			gen_poly[2]   = '0;
			gen_poly[3]   = '0;
			rate_denom    = NPOL_W'(2);
			frame_len     = FLEN_W'(64);
			enc_memory    = '0;
			bits_in_frame = 0;
			owed_code_beats.delete();
			mismatches    = 0;
			outstanding   = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_POLY_ZERO, REG_POLY_ONE, REG_POLY_TWO, REG_POLY_THREE:
						gen_poly[cfg_index] = cfg_data[POLY_W-1:0];
					REG_NUM_POLYS:    rate_denom = cfg_data[NPOL_W-1:0];
					REG_FRAME_LENGTH: frame_len = cfg_data[FLEN_W-1:0];
					default: ;
				endcase
			end
			// Compare before predicting: no bit reaches the output in its own cycle.
			if (m_tvalid && m_tready) check_code_beat();
			if (s_tvalid && s_tready) encode_info_bit(s_tdata[0]);
			outstanding = owed_code_beats.size();
		end
	end

endmodule

@@ tb/feedforward_convolutional_encoder_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feedforward_convolutional_encoder_core_test
// Drives information bits and generator settings into the encoder and leaves
// prediction and comparison of the coded beats to the stream checker.
// ----------------------------------------------------------------------------
module feedforward_convolutional_encoder_core_test;
	import fce_pkg::*;

	// Register indexes the block does not implement; writes to them must vanish.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	localparam int unsigned RESET_CYCLES   = 12;
	localparam int unsigned RX_HOLD_CYCLES = 200;
	localparam int unsigned PHASE_BITS     = 25;
	localparam int unsigned DRAIN_CYCLES   = 20;
	// Worst case is roughly 320 bits times nine beats behind a 45 percent stall
	// plus the long hold; this is many times that.
	localparam int unsigned CYCLE_LIMIT    = 200000;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	wire                   s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	wire                   m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	wire  [OUT_DATA_W-1:0] m_axis_tdata;
	wire  [OUT_USER_W-1:0] m_axis_tuser;
	wire                   m_axis_tlast;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int unsigned mismatches;
	int unsigned outstanding;

	// Idle percentages of each side, and a request for one long receiver hold.
	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	logic        rx_hold_req = 1'b0;

	feedforward_convolutional_encoder_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	fce_coded_stream_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_axis_tvalid),
		.s_tready   (s_axis_tready),
		.s_tdata    (s_axis_tdata),
		.m_tvalid   (m_axis_tvalid),
		.m_tready   (m_axis_tready),
		.m_tdata    (m_axis_tdata),
		.m_tuser    (m_axis_tuser),
		.m_tlast    (m_axis_tlast),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Receiver: random back-pressure, or one long hold when asked for. The hold
	// is counted here so that the sender keeps offering bits meanwhile and the
	// block's queue fills and closes its input.
	initial begin : receiver
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				hold_left   = RX_HOLD_CYCLES;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Verification failed");
		$finish;
	end

	// One configuration write. The wait after the enable is lowered keeps it from
	// being lowered and raised in one step when writes follow each other.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(val);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// Offers one information bit, with random idle cycles before it, and
	// returns at the edge where the beat is taken. Valid stays high so that
	// back-to-back bits go out without a bubble.
	task automatic send_info_bit(input logic b);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_DATA_W-1){1'b0}}, b};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic send_bits(input logic [31:0] bits, input int unsigned count);
		for (int i = 0; i < count; i++) send_info_bit(bits[i]);
	endtask

	// Stops offering and waits until the checker owes no coded beat, which is
	// also when the block is idle and may be reconfigured.
	task automatic drain_encoder();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	function automatic int unsigned pick_poly();
		case ($urandom_range(9))
			0:       return 0;
			1:       return 1;
			2:       return (1 << POLY_W) - 1;
			default: return $urandom_range(2, (1 << POLY_W) - 1);
		endcase
	endfunction

	function automatic int unsigned pick_frame_length();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 75) return $urandom_range(1, 12);
		if (r < 85) return 0;
		if (r < 95) return $urandom_range(13, 80);
		return (1 << FLEN_W) - 1;
	endfunction

	// A random setting followed by random bits. Phases may end mid-frame, so
	// the next setting sees leftover memory and a running bit count.
	task automatic random_phase(input int unsigned count, input logic stress);
		write_reg(REG_POLY_ZERO, pick_poly());
		write_reg(REG_POLY_ONE, pick_poly());
		write_reg(REG_POLY_TWO, pick_poly());
		write_reg(REG_POLY_THREE, pick_poly());
		write_reg(REG_NUM_POLYS,
		          ($urandom_range(9) < 7) ? $urandom_range(2, 4) : $urandom_range(0, 7));
		write_reg(REG_FRAME_LENGTH, stress ? $urandom_range(1, 4) : pick_frame_length());
		if ($urandom_range(7) == 0) write_reg(REG_SPARE_HI, $urandom_range(65535));
		for (int i = 0; i < count; i++) begin
			// Stress phases pile beats up behind a long receiver hold, and later
			// let the sender wait out every owed beat before going on.
			if (stress && i == 3) rx_hold_req = 1'b1;
			if (stress && i == count / 2) drain_encoder();
			send_info_bit($urandom_range(1));
		end
		drain_encoder();
	endtask

	initial begin : stimulus
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		tx_idle_pct = 11;
		rx_idle_pct = 45;

		// Reset setting (7 and 5, rate one half, 64-bit frames): a few bits
		// into a frame.
		send_bits(32'b1101, 4);
		drain_encoder();

		// Widest generator with all four active and one-bit frames: every bit
		// closes a frame with eight tail beats. The memory left from the short
		// code above is used under the longer memory.
		write_reg(REG_POLY_ZERO, 511);
		write_reg(REG_POLY_ONE, 0);
		write_reg(REG_POLY_TWO, 'h155);
		write_reg(REG_POLY_THREE, 'h0AA);
		write_reg(REG_NUM_POLYS, 4);
		write_reg(REG_FRAME_LENGTH, 1);
		send_bits(32'b101, 3);
		drain_encoder();

		// A rate above four saturates, and a zero frame length acts as one.
		write_reg(REG_NUM_POLYS, 7);
		write_reg(REG_FRAME_LENGTH, 0);
		send_bits(32'b10, 2);
		drain_encoder();

		// Generators that tap only the input bit give no memory: each bit
		// yields a single error beat. A rate of zero acts as two here.
		write_reg(REG_POLY_ZERO, 1);
		write_reg(REG_POLY_ONE, 0);
		write_reg(REG_NUM_POLYS, 0);
		send_bits(32'b01, 2);
		drain_encoder();

		// Writes to an unknown index are dropped. Memory of one, three
		// generators, the longest frame length.
		write_reg(REG_SPARE_LO, 16'hFFFF);
		write_reg(REG_POLY_ZERO, 3);
		write_reg(REG_POLY_ONE, 2);
		write_reg(REG_POLY_TWO, 1);
		write_reg(REG_NUM_POLYS, 3);
		write_reg(REG_FRAME_LENGTH, 65535);
		send_bits(32'b11011, 5);
		drain_encoder();

		// Frame length cut below the running count: the next bit ends the frame.
		write_reg(REG_FRAME_LENGTH, 2);
		send_bits(32'b10, 2);
		drain_encoder();

		// Random part in three idling modes; the last one runs flat out.
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					tx_idle_pct = 11;
					rx_idle_pct = 45;
				end
				1: begin
					tx_idle_pct = 45;
					rx_idle_pct = 11;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			for (int ph = 0; ph < 4; ph++)
				random_phase(PHASE_BITS, (mode != 1) && (ph == 1));
		end

		drain_encoder();
		// Room for any stray beat the block might still send.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
